>>> rtl/psmne_pkg.sv
// Shared types and constants for the pedal scan to MIDI note event unit.
// No dependencies; every other file of the block imports this package.
package psmne_pkg;

  // Configuration port widths
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIDI_CHANNEL  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_PEDALS = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MONO_MODE     = 8'd2;

  // MIDI message constants
  localparam int NOTE_W = 7;
  localparam logic [7:0]        STATUS_NOTE_ON = 8'h90;
  localparam logic [7:0]        STATUS_NONE    = 8'h00;
  localparam logic [NOTE_W-1:0] TOP_NOTE       = 7'd48;
  localparam logic [NOTE_W-1:0] VEL_PRESS      = 7'h7F;
  localparam logic [NOTE_W-1:0] VEL_RELEASE    = 7'h00;

  // Live configuration
  typedef struct packed {
    logic [3:0] midi_channel;
    logic       invert_pedals;
    logic       mono_mode;
  } cfg_t;

  // Back-end sequencer states
  typedef enum logic {
    BACK_IDLE,
    BACK_RUN
  } back_state_e;

endpackage

>>> rtl/psmne_if.sv
// Handshake channel interfaces: pedal scans in, note events out, config writes.
// Depends on psmne_pkg for the configuration port widths.
interface psmne_scan_if #(
  parameter int NUM_PEDALS = 25
);
  logic                  valid;
  logic                  ready;
  logic [NUM_PEDALS-1:0] pedal_levels;

  modport source (output valid, output pedal_levels, input ready);
  modport sink   (input valid, input pedal_levels, output ready);
endinterface

interface psmne_note_if;
  logic       valid;
  logic       ready;
  logic       has_message;
  logic [7:0] status_byte;
  logic [6:0] note_number;
  logic [6:0] velocity;
  logic       led_on;
  logic       last;

  modport source (output valid, output has_message, output status_byte,
                  output note_number, output velocity, output led_on,
                  output last, input ready);
  modport sink   (input valid, input has_message, input status_byte,
                  input note_number, input velocity, input led_on,
                  input last, output ready);
endinterface

interface psmne_cfg_if import psmne_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

>>> rtl/psmne_front.sv
// Front end: config registers, scan filtering (invert, mono) and change detection.
// Depends on psmne_pkg and the channel interfaces in psmne_if.sv.
module psmne_front import psmne_pkg::*; #(
  parameter int NUM_PEDALS = 25
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  psmne_scan_if.sink            scan_i,
  psmne_cfg_if.sink             cfg_i,
  output cfg_t                  cfg_o,
  input  logic                  full_i,
  output logic                  push_o,
  output logic [NUM_PEDALS-1:0] change_o,
  output logic [NUM_PEDALS-1:0] levels_o,
  output logic                  led_o
);

  cfg_t                  cfg_q;
  logic [NUM_PEDALS-1:0] prev_q;
  logic [NUM_PEDALS-1:0] filt;
  logic [NUM_PEDALS-1:0] pressed;
  logic [NUM_PEDALS-1:0] smear;
  logic [NUM_PEDALS-1:0] keep;
  logic [NUM_PEDALS-1:0] new_levels;

  // Take config writes at any time; unknown indexes are dropped
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.reg_index)
        REG_MIDI_CHANNEL:  cfg_q.midi_channel  <= cfg_i.wdata[3:0];
        REG_INVERT_PEDALS: cfg_q.invert_pedals <= cfg_i.wdata[0];
        REG_MONO_MODE:     cfg_q.mono_mode     <= cfg_i.wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

  // Filter the scan: invert, then keep only the highest pressed index in mono mode
  always_comb begin
    filt    = cfg_q.invert_pedals ? ~scan_i.pedal_levels : scan_i.pedal_levels;
    pressed = ~filt;
    smear   = pressed;
    for (int sh = 1; sh < NUM_PEDALS; sh = sh * 2) begin
      smear = smear | (smear >> sh);
    end
    keep       = pressed & ~(smear >> 1);
    new_levels = cfg_q.mono_mode ? ~keep : filt;
  end

  // Accept a scan whenever the queue has room
  assign scan_i.ready = !full_i;
  assign push_o       = scan_i.valid && !full_i;
  assign change_o     = new_levels ^ prev_q;
  assign levels_o     = new_levels;
  assign led_o        = ~&new_levels;

  // Hold the filtered scan for the next compare
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '1;
    end else if (push_o) begin
      prev_q <= new_levels;
    end
  end

  a_prev_follows_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> prev_q == $past(new_levels))
    else $error("previous scan not updated on accept");

endmodule

>>> rtl/psmne_fifo.sv
// Short queue of classified scans between the front end and the back end.
// Depends on psmne_pkg only through the common import convention.
module psmne_fifo import psmne_pkg::*; #(
  parameter int WIDTH = 51,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = count_q == CNT_W'(DEPTH);
  assign empty_o = count_q == '0;
  assign rdata_o = mem_q[rptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      count_q <= count_q + CNT_W'(push_i) - CNT_W'(pop_i);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

>>> rtl/psmne_back.sv
// Back end: walks the change mask of one scan and emits note items and a closing item.
// Depends on psmne_pkg and the note channel interface in psmne_if.sv.
module psmne_back import psmne_pkg::*; #(
  parameter int NUM_PEDALS = 25
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  empty_i,
  input  logic [NUM_PEDALS-1:0] change_i,
  input  logic [NUM_PEDALS-1:0] levels_i,
  input  logic                  led_i,
  output logic                  pop_o,
  psmne_note_if.source          note_o
);

  localparam int IDX_W = (NUM_PEDALS > 1) ? $clog2(NUM_PEDALS) : 1;

  back_state_e           state_q, state_d;
  logic [NUM_PEDALS-1:0] rem_q;
  logic [NUM_PEDALS-1:0] levels_q;
  logic                  led_q;
  logic [NUM_PEDALS-1:0] lowbit;
  logic [IDX_W-1:0]      idx;
  logic                  out_free;
  logic                  advance;

  logic                  valid_q;
  logic                  has_q;
  logic [7:0]            status_q;
  logic [NOTE_W-1:0]     note_q;
  logic [NOTE_W-1:0]     vel_q;
  logic                  led_out_q;
  logic                  last_q;

  assign out_free = !valid_q || note_o.ready;

  // Pick the lowest changed pedal
  always_comb begin
    lowbit = rem_q & (~rem_q + 1'b1);
    idx    = '0;
    for (int i = 0; i < NUM_PEDALS; i++) begin
      if (lowbit[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BACK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequence: load an entry, then one item per free output slot
  always_comb begin
    state_d = state_q;
    pop_o   = 1'b0;
    advance = 1'b0;
    case (state_q)
      BACK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = BACK_RUN;
        end
      end
      BACK_RUN: begin
        if (out_free) begin
          advance = 1'b1;
          if (rem_q == '0) begin
            state_d = BACK_IDLE;
          end
        end
      end
      default: state_d = BACK_IDLE;
    endcase
  end

  // Load the scan and clear each change once emitted
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rem_q    <= change_i;
      levels_q <= levels_i;
      led_q    <= led_i;
    end else if (advance) begin
      rem_q <= rem_q & ~lowbit;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (out_free) begin
      valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      led_out_q <= led_q;
      if (rem_q != '0) begin
        has_q    <= 1'b1;
        status_q <= STATUS_NOTE_ON | {4'b0000, cfg_i.midi_channel};
        note_q   <= TOP_NOTE - NOTE_W'(idx);
        vel_q    <= |(lowbit & ~levels_q) ? VEL_PRESS : VEL_RELEASE;
        last_q   <= 1'b0;
      end else begin
        has_q    <= 1'b0;
        status_q <= STATUS_NONE;
        note_q   <= '0;
        vel_q    <= VEL_RELEASE;
        last_q   <= 1'b1;
      end
    end
  end

  assign note_o.valid       = valid_q;
  assign note_o.has_message = has_q;
  assign note_o.status_byte = status_q;
  assign note_o.note_number = note_q;
  assign note_o.velocity    = vel_q;
  assign note_o.led_on      = led_out_q;
  assign note_o.last        = last_q;

  a_one_change_per_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && rem_q != '0) |=> $countones(rem_q) == $past($countones(rem_q)) - 1)
    else $error("note item did not retire exactly one change");

  a_close_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && rem_q == '0) |=> state_q == BACK_IDLE && valid_q && last_q)
    else $error("closing item not issued at end of scan");

  a_no_load_while_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BACK_RUN) |-> !pop_o)
    else $error("queue popped while a scan is in progress");

endmodule

>>> rtl/pedal_scan_midi_note_events_unit.sv
// Pedal board scan to MIDI note events: a scan of active-low contacts is taken
// whenever the two-entry scan queue has room. The back-end sequencer then loads
// the scan, emits one note item per changed pedal and then a closing item, and
// loads no new scan until that closing item is issued; that sequencer, emitting one
// item per cycle into an output register while the note channel is ready, sets the
// sustained rate. Config writes are taken every cycle and act at once.
// Depends on psmne_pkg, psmne_if.sv, psmne_front, psmne_fifo and psmne_back.
module pedal_scan_midi_note_events_unit import psmne_pkg::*; #(
  parameter int NUM_PEDALS = 25
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  psmne_scan_if.sink    scan_i,
  psmne_cfg_if.sink     cfg_i,
  psmne_note_if.source  note_o
);

  localparam int ENTRY_W = 2 * NUM_PEDALS + 1;

  cfg_t                  cfg;
  logic                  push, pop, full, empty;
  logic [NUM_PEDALS-1:0] f_change, f_levels;
  logic                  f_led;
  logic [ENTRY_W-1:0]    q_wdata, q_rdata;

  psmne_front #(.NUM_PEDALS(NUM_PEDALS)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .scan_i   (scan_i),
    .cfg_i    (cfg_i),
    .cfg_o    (cfg),
    .full_i   (full),
    .push_o   (push),
    .change_o (f_change),
    .levels_o (f_levels),
    .led_o    (f_led)
  );

  assign q_wdata = {f_led, f_levels, f_change};

  psmne_fifo #(.WIDTH(ENTRY_W), .DEPTH(2)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (q_rdata),
    .empty_o (empty)
  );

  psmne_back #(.NUM_PEDALS(NUM_PEDALS)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .empty_i  (empty),
    .change_i (q_rdata[NUM_PEDALS-1:0]),
    .levels_i (q_rdata[2*NUM_PEDALS-1:NUM_PEDALS]),
    .led_i    (q_rdata[ENTRY_W-1]),
    .pop_o    (pop),
    .note_o   (note_o)
  );

endmodule
